// ----- sv/rcu_pkg.sv -----
// Shared types and constants for the reaction coordinate unit.
// No dependencies; imported by every module of the block.
package rcu_pkg;

    // Default widths of the coordinate format.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BOX_X = 2'd0,
        CFG_BOX_Y = 2'd1,
        CFG_BOX_Z = 2'd2
    } t_cfg_reg;

    // Coordinate kinds carried on tuser.
    typedef enum logic [1:0] {
        KIND_PAIR     = 2'd0,
        KIND_DIFF     = 2'd1,
        KIND_PERIODIC = 2'd2,
        KIND_PERIODIC_ALT = 2'd3
    } t_kind;

endpackage

// ----- sv/rcu_wrap.sv -----
// Pipelined minimum image wrap of one displacement component.
// Depends on rcu_pkg; remainder is found one bit per stage.
module rcu_wrap
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic                          i_wrap_en,
    input  logic [COORD_WIDTH-2:0]        i_box_len,
    input  logic signed [COORD_WIDTH:0]   i_disp,
    output logic signed [COORD_WIDTH:0]   o_disp
);

    localparam int W  = COORD_WIDTH;
    localparam int NW = W + 2;

    logic [NW-1:0]      r_num  [0:NW];
    logic [W-1:0]       r_rem  [0:NW];
    logic               r_neg  [0:NW];
    logic               r_byp  [0:NW];
    logic signed [W:0]  r_disp [0:NW];
    logic signed [W:0]  r_out;

    logic signed [W+2:0] n_sum;
    logic [W-1:0]        n_div;
    logic [W-1:0]        n_fold;
    logic signed [W:0]   n_diff;

    // Numerator 2d + L and modulus 2L.
    assign n_sum = {{1{i_disp[W]}}, i_disp, 1'b0} + {4'b0, i_box_len};
    assign n_div = {i_box_len, 1'b0};

    // Floor remainder from the magnitude remainder, then (r - L) / 2.
    assign n_fold = (r_neg[NW] && (r_rem[NW] != '0)) ? (n_div - r_rem[NW]) : r_rem[NW];
    assign n_diff = $signed({1'b0, n_fold}) - $signed({2'b0, i_box_len});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_neg[0]  <= n_sum[W+2];
            r_num[0]  <= n_sum[W+2] ? NW'(-n_sum) : n_sum[NW-1:0];
            r_rem[0]  <= '0;
            r_byp[0]  <= !i_wrap_en || (i_box_len == '0);
            r_disp[0] <= i_disp;
            // One restoring step per stage, most significant bit first.
            for (int k = 0; k < NW; k++) begin
                logic [W:0] t;
                t = {r_rem[k], r_num[k][NW-1-k]};
                if (t >= {1'b0, n_div}) begin
                    r_rem[k+1] <= W'(t - {1'b0, n_div});
                end else begin
                    r_rem[k+1] <= t[W-1:0];
                end
                r_num[k+1]  <= r_num[k];
                r_neg[k+1]  <= r_neg[k];
                r_byp[k+1]  <= r_byp[k];
                r_disp[k+1] <= r_disp[k];
            end
            r_out <= r_byp[NW] ? r_disp[NW] : (n_diff >>> 1);
        end
    end

    assign o_disp = r_out;

endmodule

// ----- sv/rcu_len.sv -----
// Pipelined rounded Euclidean length of a three component vector.
// Depends on rcu_pkg; squares, sums, then one root bit per stage.
module rcu_len
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic signed [COORD_WIDTH:0] i_dx,
    input  logic signed [COORD_WIDTH:0] i_dy,
    input  logic signed [COORD_WIDTH:0] i_dz,
    output logic [COORD_WIDTH:0]        o_len
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = 2 * W + 2;
    localparam int SQ = W + 1;

    logic [W-1:0]   r_mx, r_my, r_mz;
    logic [2*W-1:0] r_px, r_py, r_pz;
    logic [SW-1:0]  r_sum  [0:SQ];
    logic [W+1:0]   r_rem  [0:SQ];
    logic [W:0]     r_root [0:SQ];
    logic [W:0]     r_len;

    function automatic logic [W-1:0] mag(input logic signed [W:0] d);
        logic [W:0] m;
        m = d[W] ? (W+1)'(-d) : d;
        return m[W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // Magnitudes, then squares, then the sum.
            r_mx <= mag(i_dx);
            r_my <= mag(i_dy);
            r_mz <= mag(i_dz);
            r_px <= r_mx * r_mx;
            r_py <= r_my * r_my;
            r_pz <= r_mz * r_mz;
            r_sum[0]  <= {2'b0, r_px} + {2'b0, r_py} + {2'b0, r_pz};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            // Digit by digit square root, two sum bits per stage.
            for (int k = 0; k < SQ; k++) begin
                logic [W+3:0] t;
                logic [W+3:0] trial;
                t     = {r_rem[k], r_sum[k][SW-1-2*k -: 2]};
                trial = {1'b0, r_root[k], 2'b01};
                if (t >= trial) begin
                    r_rem[k+1]  <= (W+2)'(t - trial);
                    r_root[k+1] <= {r_root[k][W-1:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= t[W+1:0];
                    r_root[k+1] <= {r_root[k][W-1:0], 1'b0};
                end
                r_sum[k+1] <= r_sum[k];
            end
            // Round to nearest: remainder above root means the next integer.
            r_len <= (r_rem[SQ] > {1'b0, r_root[SQ]}) ? r_root[SQ] + 1'b1 : r_root[SQ];
        end
    end

    assign o_len = r_len;

endmodule

// ----- sv/reaction_coordinate_unit.sv -----
// Top level of the reaction coordinate unit.
// Depends on rcu_pkg, rcu_wrap and rcu_len.
//
// Usage:
// Input transactions arrive on the slave stream: tuser carries the kind,
// tdata the nine atom coordinates. Each input transaction yields exactly one
// output transaction on the master stream: tdata carries the saturated
// coordinate, tuser the saturation flag.
// Box edges must be written on the configuration port while the block is
// idle; the block itself does not enforce this. The pipeline has one input
// stage, COORD_WIDTH+4 stages of the minimum image remainder, COORD_WIDTH+5
// stages of squaring and digit by digit square root, and one output register.
// Throughput is one transaction per cycle while the receiver accepts results;
// every stage is fully pipelined. Reset clears all valid bits and sets every
// box edge to 1.0. When the receiver stalls with a result waiting, the whole
// pipeline holds in place and o_s_tready falls; nothing is lost or repeated.
module reaction_coordinate_unit
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // left_x, left_y, left_z, middle_x, middle_y, middle_z, right_x, right_y, right_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // kind
    input  logic [1:0]                               i_s_tuser,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // coordinate
    output logic [((COORD_WIDTH+7)/8)*8-1:0]         o_m_tdata,
    // saturated
    output logic                                     o_m_tuser,
    input  logic                                     i_cfg_we,
    input  logic [1:0]                               i_cfg_index,
    input  logic [COORD_WIDTH-2:0]                   i_cfg_wdata
);

    localparam int W   = COORD_WIDTH;
    localparam int ODW = ((W + 7) / 8) * 8;
    localparam int PL  = 1 + (W + 4) + (W + 5);

    logic [W-2:0] r_box_x, r_box_y, r_box_z;
    logic         r_vld  [0:PL-1];
    logic         r_pair [0:PL-1];
    logic         r_out_vld;
    logic [W-1:0] r_coord;
    logic         r_sat;

    logic signed [W:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic              r_wrap;
    logic signed [W:0] w_ax, w_ay, w_az, w_bx, w_by, w_bz;
    logic [W:0]        w_len_a, w_len_b;

    logic              ce;
    t_kind             kind;
    logic signed [W:0] lx, ly, lz, mx, my, mz, rx, ry, rz;
    logic signed [W+1:0] n_value;

    assign ce         = !r_out_vld || i_m_tready;
    assign o_s_tready = ce;
    assign kind       = t_kind'(i_s_tuser);

    // Unpack and sign extend the coordinates.
    assign lx = $signed({i_s_tdata[1*W-1], i_s_tdata[0*W +: W]});
    assign ly = $signed({i_s_tdata[2*W-1], i_s_tdata[1*W +: W]});
    assign lz = $signed({i_s_tdata[3*W-1], i_s_tdata[2*W +: W]});
    assign mx = $signed({i_s_tdata[4*W-1], i_s_tdata[3*W +: W]});
    assign my = $signed({i_s_tdata[5*W-1], i_s_tdata[4*W +: W]});
    assign mz = $signed({i_s_tdata[6*W-1], i_s_tdata[5*W +: W]});
    assign rx = $signed({i_s_tdata[7*W-1], i_s_tdata[6*W +: W]});
    assign ry = $signed({i_s_tdata[8*W-1], i_s_tdata[7*W +: W]});
    assign rz = $signed({i_s_tdata[9*W-1], i_s_tdata[8*W +: W]});

    // Box edge registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= (W-1)'(1) << FRAC_BITS;
            r_box_y <= (W-1)'(1) << FRAC_BITS;
            r_box_z <= (W-1)'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BOX_X: r_box_x <= i_cfg_wdata;
                CFG_BOX_Y: r_box_y <= i_cfg_wdata;
                CFG_BOX_Z: r_box_z <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Input stage: displacements for both lengths.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (kind == KIND_PAIR) begin
                r_ax <= rx - lx;
                r_ay <= ry - ly;
                r_az <= rz - lz;
            end else begin
                r_ax <= mx - lx;
                r_ay <= my - ly;
                r_az <= mz - lz;
            end
            r_bx   <= mx - rx;
            r_by   <= my - ry;
            r_bz   <= mz - rz;
            r_wrap <= i_s_tuser[1];
        end
    end

    // Valid and kind travel alongside the data path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (ce) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < PL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pair[0] <= (kind == KIND_PAIR);
            for (int k = 1; k < PL; k++) begin
                r_pair[k] <= r_pair[k-1];
            end
        end
    end

    // Minimum image wrap of all six components, bypassed for non-periodic kinds.
    rcu_wrap #(.COORD_WIDTH(W)) u_wrap_ax (.i_clk, .i_ce(ce), .i_wrap_en(r_wrap),
        .i_box_len(r_box_x), .i_disp(r_ax), .o_disp(w_ax));
    rcu_wrap #(.COORD_WIDTH(W)) u_wrap_ay (.i_clk, .i_ce(ce), .i_wrap_en(r_wrap),
        .i_box_len(r_box_y), .i_disp(r_ay), .o_disp(w_ay));
    rcu_wrap #(.COORD_WIDTH(W)) u_wrap_az (.i_clk, .i_ce(ce), .i_wrap_en(r_wrap),
        .i_box_len(r_box_z), .i_disp(r_az), .o_disp(w_az));
    rcu_wrap #(.COORD_WIDTH(W)) u_wrap_bx (.i_clk, .i_ce(ce), .i_wrap_en(r_wrap),
        .i_box_len(r_box_x), .i_disp(r_bx), .o_disp(w_bx));
    rcu_wrap #(.COORD_WIDTH(W)) u_wrap_by (.i_clk, .i_ce(ce), .i_wrap_en(r_wrap),
        .i_box_len(r_box_y), .i_disp(r_by), .o_disp(w_by));
    rcu_wrap #(.COORD_WIDTH(W)) u_wrap_bz (.i_clk, .i_ce(ce), .i_wrap_en(r_wrap),
        .i_box_len(r_box_z), .i_disp(r_bz), .o_disp(w_bz));

    // Two lengths.
    rcu_len #(.COORD_WIDTH(W)) u_len_a (.i_clk, .i_ce(ce),
        .i_dx(w_ax), .i_dy(w_ay), .i_dz(w_az), .o_len(w_len_a));
    rcu_len #(.COORD_WIDTH(W)) u_len_b (.i_clk, .i_ce(ce),
        .i_dx(w_bx), .i_dy(w_by), .i_dz(w_bz), .o_len(w_len_b));

    // Difference or plain length, then saturation into the output register.
    assign n_value = r_pair[PL-1] ? $signed({1'b0, w_len_a})
                                  : $signed({1'b0, w_len_a}) - $signed({1'b0, w_len_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= r_vld[PL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (n_value > $signed({3'b0, {(W-1){1'b1}}})) begin
                r_coord <= {1'b0, {(W-1){1'b1}}};
                r_sat   <= 1'b1;
            end else if (n_value < $signed({3'b111, {(W-1){1'b0}}})) begin
                r_coord <= {1'b1, {(W-1){1'b0}}};
                r_sat   <= 1'b1;
            end else begin
                r_coord <= n_value[W-1:0];
                r_sat   <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = ODW'(r_coord);
    assign o_m_tuser  = r_sat;

endmodule

// ----- sv/rcu_checker.sv -----
// Port level checker for the reaction coordinate unit, bound to the top level.
// Depends on rcu_pkg for the default width.
module rcu_checker
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_s_tready,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready,
    input logic [((COORD_WIDTH+7)/8)*8-1:0]     o_m_tdata,
    input logic                                 o_m_tuser
);

    localparam int W = COORD_WIDTH;

    // A stalled result transaction stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // With no result waiting, the input side is open.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // A clipped result sits at one of the two bounds.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[W-1:0] == {1'b0, {(W-1){1'b1}}}) ||
            (o_m_tdata[W-1:0] == {1'b1, {(W-1){1'b0}}}))
        else $error("saturation flag without bound value");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind reaction_coordinate_unit rcu_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rcu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
